/* rtl/sts_pkg.sv */
// Package with constants, payload types and status codes of the target-sum window search.
package sts_pkg;

  localparam int STS_DEPTH   = 1024;
  localparam int STS_MAX_LEN = 65536;

  localparam int STS_ADDR_W  = $clog2(STS_DEPTH);
  localparam int STS_CNT_W   = $clog2(STS_DEPTH + 1);
  localparam int STS_SEEN_W  = $clog2(STS_MAX_LEN + 2);
  localparam int STS_ELEM_W  = 16;
  localparam int STS_IDX_W   = 17;
  localparam int STS_TGT_W   = 32;
  localparam int STS_TOT_W   = 33;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [STS_ELEM_W-1:0] elem_value;
    logic                  last_item;
  } sts_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [STS_IDX_W-1:0] start_index;
    logic [STS_IDX_W-1:0] end_index;
  } sts_out_t;

  typedef struct packed {
    logic     valid;
    sts_out_t data;
  } sts_push_t;

endpackage

/* rtl/sts_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module sts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sts_out_reg.sv */
// Output register that holds one result until the receiver takes it.
module sts_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  sts_pkg::sts_push_t push,
  output logic              stall,
  output logic              out_valid,
  input  logic              out_ready,
  output sts_pkg::sts_out_t out_data
);
  import sts_pkg::*;

  assign stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_data <= push.data;
    end
  end

endmodule

/* rtl/sts_engine.sv */
// Sequencer that keeps the window state and reads, trims and extends the window memory.
module sts_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sts_pkg::sts_in_t                in_data,
  input  logic                            cfg_valid,
  input  logic [sts_pkg::STS_TGT_W-1:0]   cfg_data,
  input  logic                            stall,
  output sts_pkg::sts_push_t              push
);
  import sts_pkg::*;

  localparam int SUM_W = STS_CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TEST = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t                 state;
  logic [STS_TOT_W-1:0]   total;
  logic [STS_TGT_W-1:0]   target;
  logic [STS_ADDR_W-1:0]  head;
  logic [STS_CNT_W-1:0]   count;
  logic [STS_SEEN_W-1:0]  seen;
  logic [STS_SEEN_W-1:0]  start;
  logic                   done;
  logic                   kept;
  logic                   over_len;
  logic [STS_ELEM_W-1:0]  item_v;
  logic                   item_last;

  logic [STS_ELEM_W-1:0]  rd_data;
  logic                   rd_en;
  logic                   wr_en;
  logic [SUM_W-1:0]       tail_sum;
  logic [STS_ADDR_W-1:0]  tail;
  logic [STS_ADDR_W-1:0]  head_next;
  logic                   above;
  logic                   found;
  logic                   full;
  logic                   need_res;
  logic                   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign above    = total > {1'b0, target};
  assign found    = kept && (total == {1'b0, target});
  assign full     = kept && !found && (count >= STS_CNT_W'(STS_DEPTH));
  assign need_res = found || full || item_last;

  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= SUM_W'(STS_DEPTH)) ?
                    STS_ADDR_W'(tail_sum - SUM_W'(STS_DEPTH)) : STS_ADDR_W'(tail_sum);
  assign head_next = (head == STS_ADDR_W'(STS_DEPTH - 1)) ? '0 : head + 1'b1;

  assign rd_en = (state == S_TEST) && !over_len && above && (count != '0);
  assign wr_en = (state == S_TEST) && !over_len && !above && kept && !found && !full &&
                 !(item_last && stall);

  sts_ram #(
    .WIDTH (STS_ELEM_W),
    .DEPTH (STS_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (item_v),
    .re    (rd_en),
    .raddr (head),
    .rdata (rd_data)
  );

  always_comb begin
    push.valid            = 1'b0;
    push.data.status      = ST_OVERFLOW;
    push.data.start_index = '0;
    push.data.end_index   = '0;
    if (state == S_TEST && !stall) begin
      if (over_len) begin
        push.valid = 1'b1;
      end else if (!above && need_res) begin
        push.valid = 1'b1;
        if (found) begin
          push.data.status      = ST_FOUND;
          push.data.start_index = STS_IDX_W'(start);
          push.data.end_index   = STS_IDX_W'(seen);
        end else if (!full) begin
          push.data.status = ST_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      target   <= STS_TGT_W'(1);
      total    <= '0;
      head     <= '0;
      count    <= '0;
      seen     <= '0;
      start    <= STS_SEEN_W'(1);
      done     <= 1'b0;
      kept     <= 1'b0;
      over_len <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_v    <= in_data.elem_value;
            item_last <= in_data.last_item;
            if (done) begin
              if (in_data.last_item) begin
                total <= '0;
                head  <= '0;
                count <= '0;
                seen  <= '0;
                start <= STS_SEEN_W'(1);
                done  <= 1'b0;
              end
            end else if (seen >= STS_SEEN_W'(STS_MAX_LEN)) begin
              over_len <= 1'b1;
              state    <= S_TEST;
            end else begin
              seen     <= seen + 1'b1;
              total    <= total + STS_TOT_W'(in_data.elem_value);
              kept     <= 1'b1;
              over_len <= 1'b0;
              state    <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (over_len) begin
            if (!stall) begin
              over_len <= 1'b0;
              state    <= S_IDLE;
              if (item_last) begin
                total <= '0;
                head  <= '0;
                count <= '0;
                seen  <= '0;
                start <= STS_SEEN_W'(1);
                done  <= 1'b0;
              end else begin
                done <= 1'b1;
              end
            end
          end else if (above) begin
            if (count != '0) begin
              state <= S_POP;
            end else begin
              total <= total - STS_TOT_W'(item_v);
              start <= start + 1'b1;
              kept  <= 1'b0;
            end
          end else if (!(need_res && stall)) begin
            state <= S_IDLE;
            if (wr_en) begin
              count <= count + 1'b1;
            end
            if (item_last) begin
              total <= '0;
              head  <= '0;
              count <= '0;
              seen  <= '0;
              start <= STS_SEEN_W'(1);
              done  <= 1'b0;
            end else if (found || full) begin
              done <= 1'b1;
            end
          end
        end
        S_POP: begin
          total <= total - STS_TOT_W'(rd_data);
          head  <= head_next;
          count <= count - 1'b1;
          start <= start + 1'b1;
          state <= S_TEST;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/subarray_target_sum_window.sv */
// Top level of the streaming search for the first window whose sum equals a target.
//
// Elements arrive on the input channel (in_valid, in_ready, in_data) and results
// leave on the output channel (out_valid, out_ready, out_data); each transfer
// takes place when valid and ready are both high. The target is written on the
// configuration channel (cfg_valid, cfg_ready, cfg_data), which is always ready.
// Each element is registered and tested against the target; every element
// dropped from the front reads the window memory and waits for its registered
// data, and an element that alone exceeds the target is dropped itself.
// Elements that follow a result in the same stream are taken without a test.
// A result, when an element causes one, goes from the test state into the
// output register. The input is ready again as soon as the element is finished,
// even while an earlier result waits in the output register.
// When the receiver stalls and a new result is due, the block holds that element
// and keeps in_ready low until the output register frees.
// Reset clears the window, sets the target to one and empties the output; the
// window memory needs no clearing because only entries written in the current
// stream are read.
module subarray_target_sum_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sts_pkg::sts_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sts_pkg::sts_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sts_pkg::STS_TGT_W-1:0] cfg_data
);
  import sts_pkg::*;

  sts_push_t push;
  logic      stall;

  assign cfg_ready = 1'b1;

  sts_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .stall     (stall),
    .push      (push)
  );

  sts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .stall     (stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/sts_checker.sv */
// Port-level checker for the target-sum window search and its bind to the top level.
module sts_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input sts_pkg::sts_out_t out_data
);
  import sts_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output is valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FOUND |->
      out_data.start_index != '0 && out_data.start_index <= out_data.end_index)
    else $error("Found result has an invalid index range.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NOTFOUND || out_data.status == ST_OVERFLOW) |->
      out_data.start_index == '0 && out_data.end_index == '0)
    else $error("Result without match carries indices.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_FOUND || out_data.status == ST_NOTFOUND ||
                  out_data.status == ST_OVERFLOW)
    else $error("Result carries an unused status code.");

endmodule

bind subarray_target_sum_window sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
